>>> hdl/mst_pkg.sv
// ---------------------------------------------------------------------------
// mst_pkg: shared types and constants of the sustain note tracker
// command and result codes, queue word layout, sizes derived from note count
// ---------------------------------------------------------------------------
package mst_pkg;

   // number of tracked notes, 16 to 128
   localparam int NUM_NOTES   = 128;
   localparam int NOTE_W      = $clog2(NUM_NOTES);
   localparam int NOTE_FIELD_W = 7;
   localparam logic [7:0] NOTE_LIMIT = 8'(NUM_NOTES);

   // bulk release is reported per group of 16 notes
   localparam int GROUP_SIZE  = 16;
   localparam int NUM_GROUPS  = (NUM_NOTES + GROUP_SIZE - 1) / GROUP_SIZE;
   localparam int GROUP_BITS  = NUM_GROUPS * GROUP_SIZE;

   // queue between front and back, depth is a power of two
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   // input command codes
   localparam logic [2:0] CMD_NOTE_ON  = 3'd0;
   localparam logic [2:0] CMD_NOTE_OFF = 3'd1;
   localparam logic [2:0] CMD_PEDAL    = 3'd2;
   localparam logic [2:0] CMD_ALL_OFF  = 3'd3;
   localparam logic [2:0] CMD_QUERY    = 3'd4;

   // result kinds
   localparam logic [1:0] KIND_STATUS   = 2'd0;
   localparam logic [1:0] KIND_NOTE_ON  = 2'd1;
   localparam logic [1:0] KIND_NOTE_OFF = 2'd2;
   localparam logic [1:0] KIND_GROUP    = 2'd3;

   // classified operation handed from front to back
   typedef enum logic [2:0] {
      OP_NOP,
      OP_NOTE_ON,
      OP_NOTE_OFF,
      OP_PEDAL,
      OP_ALL_OFF,
      OP_QUERY
   } mst_op_type;

   typedef struct packed {
      mst_op_type              op;
      logic [NOTE_FIELD_W-1:0] note;
      logic                    pedal_down;
   } mst_entry_type;

   typedef struct packed {
      logic [1:0]              kind;
      logic [NOTE_FIELD_W-1:0] event_note;
      logic [GROUP_SIZE-1:0]   release_mask;
      logic                    is_sounding;
      logic                    is_key_down;
      logic [7:0]              sounding_count;
      logic [31:0]             generation;
      logic                    last;
   } mst_rsp_type;

   typedef enum logic {
      BK_IDLE,
      BK_SCAN
   } mst_back_state_type;

endpackage

>>> hdl/mst_front.sv
// ---------------------------------------------------------------------------
// mst_front: command intake and classification
// turns a request word into a queue entry, folding the simple cases early
// ---------------------------------------------------------------------------
module mst_front (
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [2:0]                       req_cmd,
   input  logic [mst_pkg::NOTE_FIELD_W-1:0] req_note,
   input  logic [6:0]                       req_velocity,
   input  logic                             req_pedal_down,
   input  logic                             queue_full,
   output logic                             push,
   output mst_pkg::mst_entry_type           push_entry
);

   logic note_ok;

   assign note_ok   = {1'b0, req_note} < mst_pkg::NOTE_LIMIT;
   assign req_stall = queue_full;
   assign push      = req_valid && !queue_full;

   always_comb begin
      push_entry.note       = req_note;
      push_entry.pedal_down = req_pedal_down;
      push_entry.op         = mst_pkg::OP_NOP;
      case (req_cmd)
         mst_pkg::CMD_NOTE_ON: begin
            // zero velocity is a note off
            if (note_ok) begin
               push_entry.op = (req_velocity == 7'd0) ? mst_pkg::OP_NOTE_OFF
                                                      : mst_pkg::OP_NOTE_ON;
            end
         end
         mst_pkg::CMD_NOTE_OFF: begin
            if (note_ok) begin
               push_entry.op = mst_pkg::OP_NOTE_OFF;
            end
         end
         mst_pkg::CMD_PEDAL:   push_entry.op = mst_pkg::OP_PEDAL;
         mst_pkg::CMD_ALL_OFF: push_entry.op = mst_pkg::OP_ALL_OFF;
         mst_pkg::CMD_QUERY: begin
            // out of range query answers zeros, same as a no-op status
            if (note_ok) begin
               push_entry.op = mst_pkg::OP_QUERY;
            end
         end
         default: push_entry.op = mst_pkg::OP_NOP;
      endcase
   end

endmodule

>>> hdl/mst_fifo.sv
// ---------------------------------------------------------------------------
// mst_fifo: short queue between front and back
// holds classified entries so each side can stall on its own
// ---------------------------------------------------------------------------
module mst_fifo (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  mst_pkg::mst_entry_type push_entry,
   output logic                   full,
   input  logic                   pop,
   output logic                   pop_valid,
   output mst_pkg::mst_entry_type pop_entry
);

   mst_pkg::mst_entry_type           slot_ff [mst_pkg::QUEUE_DEPTH];
   logic [mst_pkg::QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [mst_pkg::QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [mst_pkg::QUEUE_CNT_W-1:0] fill_ff, fill_in;

   assign full      = fill_ff == mst_pkg::QUEUE_CNT_W'(mst_pkg::QUEUE_DEPTH);
   assign pop_valid = fill_ff != '0;
   assign pop_entry = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      fill_in   = fill_ff;
      if (push && !pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (pop && !push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

>>> hdl/mst_back.sv
// ---------------------------------------------------------------------------
// mst_back: note state and result generation
// applies one queued entry at a time, scans bulk releases group by group
// ---------------------------------------------------------------------------
module mst_back (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   forward_enable,
   input  logic                   q_valid,
   input  mst_pkg::mst_entry_type q_entry,
   output logic                   q_pop,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output mst_pkg::mst_rsp_type   rsp
);

   mst_pkg::mst_back_state_type state_ff, state_in;

   logic [mst_pkg::NUM_NOTES-1:0]  key_ff, key_in;
   logic [mst_pkg::NUM_NOTES-1:0]  hold_ff, hold_in;
   logic                           pedal_ff, pedal_in;
   logic [7:0]                     count_ff, count_in;
   logic [7:0]                     key_count_ff, key_count_in;
   logic [31:0]                    gen_ff, gen_in;
   logic [mst_pkg::GROUP_BITS-1:0] rel_ff, rel_in;
   logic [mst_pkg::NOTE_FIELD_W-1:0] base_ff, base_in;
   mst_pkg::mst_rsp_type           rsp_ff, rsp_in;
   logic                           rsp_valid_ff, rsp_valid_in;

   logic                           out_free;
   logic [mst_pkg::NOTE_W-1:0]     cur_idx;
   logic                           cur_kh;
   logic                           cur_hp;
   logic                           cur_snd;
   logic [31:0]                    gen_step;
   logic                           bulk;
   logic [mst_pkg::NUM_NOTES-1:0]  bulk_rel;
   logic [mst_pkg::GROUP_SIZE-1:0] grp;
   logic [mst_pkg::GROUP_BITS-1:0] rest;
   logic                           rest_any;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign cur_idx   = q_entry.note[mst_pkg::NOTE_W-1:0];
   assign cur_kh    = key_ff[cur_idx];
   assign cur_hp    = hold_ff[cur_idx];
   assign cur_snd   = cur_kh || cur_hp;
   assign gen_step  = gen_ff + 32'd1;
   assign grp       = rel_ff[mst_pkg::GROUP_SIZE-1:0];
   assign rest      = rel_ff >> mst_pkg::GROUP_SIZE;
   assign rest_any  = |rest;
   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   always_comb begin
      state_in     = state_ff;
      key_in       = key_ff;
      hold_in      = hold_ff;
      pedal_in     = pedal_ff;
      count_in     = count_ff;
      key_count_in = key_count_ff;
      gen_in       = gen_ff;
      rel_in       = rel_ff;
      base_in      = base_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      q_pop        = 1'b0;
      bulk         = 1'b0;
      bulk_rel     = '0;
      case (state_ff)
         mst_pkg::BK_IDLE: begin
            if (q_valid && out_free) begin
               q_pop               = 1'b1;
               rsp_valid_in        = 1'b1;
               rsp_in.kind         = mst_pkg::KIND_STATUS;
               rsp_in.event_note   = '0;
               rsp_in.release_mask = '0;
               rsp_in.is_sounding  = 1'b0;
               rsp_in.is_key_down  = 1'b0;
               rsp_in.last         = 1'b1;
               case (q_entry.op)
                  mst_pkg::OP_NOTE_ON: begin
                     key_in[cur_idx]  = 1'b1;
                     hold_in[cur_idx] = 1'b0;
                     count_in     = count_ff + {7'd0, ~cur_snd};
                     key_count_in = key_count_ff + {7'd0, ~cur_kh};
                     gen_in       = gen_step;
                     if (forward_enable) begin
                        rsp_in.kind       = mst_pkg::KIND_NOTE_ON;
                        rsp_in.event_note = q_entry.note;
                     end
                  end
                  mst_pkg::OP_NOTE_OFF: begin
                     key_in[cur_idx]  = 1'b0;
                     hold_in[cur_idx] = pedal_ff;
                     // pedal down keeps the note sounding as sustained
                     if (pedal_ff) begin
                        count_in = count_ff + {7'd0, ~cur_snd};
                     end else begin
                        count_in = count_ff - {7'd0, cur_snd};
                     end
                     key_count_in = key_count_ff - {7'd0, cur_kh};
                     gen_in       = gen_step;
                     if (forward_enable && !pedal_ff) begin
                        rsp_in.kind       = mst_pkg::KIND_NOTE_OFF;
                        rsp_in.event_note = q_entry.note;
                     end
                  end
                  mst_pkg::OP_PEDAL: begin
                     if (q_entry.pedal_down != pedal_ff) begin
                        pedal_in = q_entry.pedal_down;
                        gen_in   = gen_step;
                        if (!q_entry.pedal_down) begin
                           // release: sustained notes with key up drop out
                           bulk     = 1'b1;
                           bulk_rel = hold_ff & ~key_ff;
                           hold_in  = '0;
                           count_in = key_count_ff;
                        end
                     end
                  end
                  mst_pkg::OP_ALL_OFF: begin
                     bulk         = 1'b1;
                     bulk_rel     = key_ff | hold_ff;
                     key_in       = '0;
                     hold_in      = '0;
                     pedal_in     = 1'b0;
                     count_in     = '0;
                     key_count_in = '0;
                     gen_in       = gen_step;
                  end
                  mst_pkg::OP_QUERY: begin
                     rsp_in.is_sounding = cur_snd;
                     rsp_in.is_key_down = cur_kh;
                  end
                  default: ;
               endcase
               rsp_in.sounding_count = count_in;
               rsp_in.generation     = gen_in;
               if (bulk && forward_enable && (bulk_rel != '0)) begin
                  rsp_valid_in = 1'b0;
                  rel_in       = mst_pkg::GROUP_BITS'(bulk_rel);
                  base_in      = '0;
                  state_in     = mst_pkg::BK_SCAN;
               end
            end
         end
         mst_pkg::BK_SCAN: begin
            // empty groups are skipped without waiting on the output
            if ((grp == '0) || out_free) begin
               rel_in  = rest;
               base_in = base_ff + mst_pkg::NOTE_FIELD_W'(mst_pkg::GROUP_SIZE);
               if (grp != '0) begin
                  rsp_valid_in          = 1'b1;
                  rsp_in.kind           = mst_pkg::KIND_GROUP;
                  rsp_in.event_note     = base_ff;
                  rsp_in.release_mask   = grp;
                  rsp_in.is_sounding    = 1'b0;
                  rsp_in.is_key_down    = 1'b0;
                  rsp_in.sounding_count = count_ff;
                  rsp_in.generation     = gen_ff;
                  rsp_in.last           = !rest_any;
               end
               if (!rest_any) begin
                  state_in = mst_pkg::BK_IDLE;
               end
            end
         end
         default: state_in = mst_pkg::BK_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mst_pkg::BK_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff       <= '0;
         hold_ff      <= '0;
         pedal_ff     <= 1'b0;
         count_ff     <= '0;
         key_count_ff <= '0;
         gen_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         key_ff       <= key_in;
         hold_ff      <= hold_in;
         pedal_ff     <= pedal_in;
         count_ff     <= count_in;
         key_count_ff <= key_count_in;
         gen_ff       <= gen_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rel_ff  <= rel_in;
      base_ff <= base_in;
      rsp_ff  <= rsp_in;
   end

endmodule

>>> hdl/midi_sustain_note_tracker_top.sv
// ---------------------------------------------------------------------------
// midi_sustain_note_tracker_top: sustain pedal note tracker, top level
// response path: an accepted request word is queued, then applied into the registered response word
// throughput: 1 request per cycle for single-word commands unless stalled; a forwarded bulk
//   release scans the 16-note groups up to the last released group before the next request
// stalls: a response stall holds the back end; the 2-entry queue stalls requests when full
// reset: synchronous, all notes, pedal, count and generation clear, forwarding on
// ---------------------------------------------------------------------------
module midi_sustain_note_tracker_top (
   input  logic                             clock,
   input  logic                             reset,
   // request channel
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [2:0]                       req_cmd,
   input  logic [mst_pkg::NOTE_FIELD_W-1:0] req_note,
   input  logic [6:0]                       req_velocity,
   input  logic                             req_pedal_down,
   // response channel
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [1:0]                       rsp_kind,
   output logic [mst_pkg::NOTE_FIELD_W-1:0] rsp_event_note,
   output logic [mst_pkg::GROUP_SIZE-1:0]   rsp_release_mask,
   output logic                             rsp_is_sounding,
   output logic                             rsp_is_key_down,
   output logic [7:0]                       rsp_sounding_count,
   output logic [31:0]                      rsp_generation,
   output logic                             rsp_last,
   // control register
   input  logic                             csr_wr_en,
   input  logic                             csr_wr_data
);

   // forward_enable register; the user must write it only while idle, the block does not enforce this
   logic                   fwd_en_ff, fwd_en_in;

   // front to queue
   logic                   push;
   mst_pkg::mst_entry_type push_entry;
   logic                   queue_full;

   // queue to back
   logic                   pop;
   logic                   pop_valid;
   mst_pkg::mst_entry_type pop_entry;

   // registered response word from the back end
   mst_pkg::mst_rsp_type   rsp;

   assign fwd_en_in = csr_wr_en ? csr_wr_data : fwd_en_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_en_ff <= 1'b1;
      end else begin
         fwd_en_ff <= fwd_en_in;
      end
   end

   // front: accepts a word, folds out-of-range notes and zero velocity
   mst_front u_front (
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_cmd        (req_cmd),
      .req_note       (req_note),
      .req_velocity   (req_velocity),
      .req_pedal_down (req_pedal_down),
      .queue_full     (queue_full),
      .push           (push),
      .push_entry     (push_entry)
   );

   // two-entry queue decouples intake from the scanning back end
   mst_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (queue_full),
      .pop        (pop),
      .pop_valid  (pop_valid),
      .pop_entry  (pop_entry)
   );

   // back: owns note state, sounding count and generation, drives responses
   mst_back u_back (
      .clock          (clock),
      .reset          (reset),
      .forward_enable (fwd_en_ff),
      .q_valid        (pop_valid),
      .q_entry        (pop_entry),
      .q_pop          (pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp            (rsp)
   );

   // response fields
   assign rsp_kind           = rsp.kind;
   assign rsp_event_note     = rsp.event_note;
   assign rsp_release_mask   = rsp.release_mask;
   assign rsp_is_sounding    = rsp.is_sounding;
   assign rsp_is_key_down    = rsp.is_key_down;
   assign rsp_sounding_count = rsp.sounding_count;
   assign rsp_generation     = rsp.generation;
   assign rsp_last           = rsp.last;

   // sounding count can never exceed the number of notes
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_sounding_count <= mst_pkg::NOTE_LIMIT))
      else $error("sounding count out of range");

   // a group word always releases at least one note
   a_group_nonempty: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_kind == mst_pkg::KIND_GROUP)) |-> (rsp_release_mask != '0))
      else $error("empty group release word");

   // query answers only appear on status words, and key down implies sounding
   a_query_bits: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_is_sounding || rsp_is_key_down)) |->
         ((rsp_kind == mst_pkg::KIND_STATUS) && rsp_is_sounding))
      else $error("query bits on a non-status word");

   // a status or single-note word is always the only word of its request
   a_single_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_kind != mst_pkg::KIND_GROUP)) |-> rsp_last)
      else $error("single word without last");

endmodule

>>> sim/midi_sustain_note_tracker_top_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// midi_sustain_note_tracker_top_tb: self-checking bench for the note tracker
// drives note, pedal, all-off and query requests through the valid/stall
// request port, tracks key and sustain state in a scoreboard of its own and
// compares every response word field by field; runs four traffic phases
// with and without idling and toggles the forwarding register between them
// ---------------------------------------------------------------------------
module midi_sustain_note_tracker_top_tb;

   localparam int CYCLE_LIMIT  = 300000;
   localparam int HOLD_CYCLES  = 500;
   localparam int ITEMS_PHASE  = 64;
   localparam int TAIL_CYCLES  = 20;
   localparam int DRAIN_CYCLES = 8;

   // key/sustain tracker and store of expected response words
   class sustain_scoreboard;
      bit                   key_down [mst_pkg::NUM_NOTES];
      bit                   sustained [mst_pkg::NUM_NOTES];
      bit                   pedal;
      bit                   forward_on = 1'b1;
      logic [7:0]           sounding = '0;
      logic [31:0]          gen_count = '0;
      mst_pkg::mst_rsp_type expected_words [$];
      mst_pkg::mst_rsp_type batch [$];
      int                   errors;

      function mst_pkg::mst_rsp_type make_word(logic [1:0] kind, logic [6:0] note,
                                               logic [mst_pkg::GROUP_SIZE-1:0] mask);
         mst_pkg::mst_rsp_type w;
         w = '0;
         w.kind = kind;
         w.event_note = note;
         w.release_mask = mask;
         return w;
      endfunction

      function void queue_word(mst_pkg::mst_rsp_type w);
         batch.insert(batch.size(), w);
      endfunction

      function void recount();
         int c;
         c = 0;
         for (int n = 0; n < mst_pkg::NUM_NOTES; n++)
            if (key_down[n] || sustained[n]) c++;
         sounding = 8'(c);
         gen_count = gen_count + 32'd1;
      endfunction

      function void release_key(logic [6:0] note);
         key_down[note] = 1'b0;
         if (pedal) begin
            sustained[note] = 1'b1;
         end else begin
            sustained[note] = 1'b0;
            if (forward_on) queue_word(make_word(mst_pkg::KIND_NOTE_OFF, note, '0));
         end
         recount();
      endfunction

      function void add_groups(logic [mst_pkg::GROUP_BITS-1:0] freed);
         logic [mst_pkg::GROUP_SIZE-1:0] mask;
         for (int g = 0; g < mst_pkg::NUM_GROUPS; g++) begin
            mask = freed[g*mst_pkg::GROUP_SIZE +: mst_pkg::GROUP_SIZE];
            if (forward_on && mask != '0)
               queue_word(make_word(mst_pkg::KIND_GROUP, 7'(g * mst_pkg::GROUP_SIZE),
                                    mask));
         end
      endfunction

      // work out the response words of one accepted request
      function void note_request(logic [2:0] cmd, logic [6:0] note,
                                 logic [6:0] vel, logic pd);
         logic [mst_pkg::GROUP_BITS-1:0] freed;
         bit                             in_range;
         bit                             q_snd;
         bit                             q_key;
         mst_pkg::mst_rsp_type           w;
         in_range = note < mst_pkg::NUM_NOTES;
         freed = '0;
         q_snd = 1'b0;
         q_key = 1'b0;
         batch.delete();
         case (cmd)
            mst_pkg::CMD_NOTE_ON: begin
               if (in_range) begin
                  if (vel == 7'd0) begin
                     release_key(note);
                  end else begin
                     key_down[note] = 1'b1;
                     sustained[note] = 1'b0;
                     if (forward_on)
                        queue_word(make_word(mst_pkg::KIND_NOTE_ON, note, '0));
                     recount();
                  end
               end
            end
            mst_pkg::CMD_NOTE_OFF: begin
               if (in_range) release_key(note);
            end
            mst_pkg::CMD_PEDAL: begin
               if (pd != pedal) begin
                  pedal = pd;
                  if (!pd) begin
                     for (int n = 0; n < mst_pkg::NUM_NOTES; n++) begin
                        if (sustained[n]) begin
                           sustained[n] = 1'b0;
                           if (!key_down[n]) freed[n] = 1'b1;
                        end
                     end
                     add_groups(freed);
                  end
                  recount();
               end
            end
            mst_pkg::CMD_ALL_OFF: begin
               for (int n = 0; n < mst_pkg::NUM_NOTES; n++) begin
                  freed[n] = key_down[n] || sustained[n];
                  key_down[n] = 1'b0;
                  sustained[n] = 1'b0;
               end
               add_groups(freed);
               pedal = 1'b0;
               recount();
            end
            mst_pkg::CMD_QUERY: begin
               if (in_range) begin
                  q_key = key_down[note];
                  q_snd = key_down[note] || sustained[note];
               end
            end
            default: ;
         endcase
         if (batch.size() == 0) begin
            w = make_word(mst_pkg::KIND_STATUS, '0, '0);
            w.is_sounding = q_snd;
            w.is_key_down = q_key;
            queue_word(w);
         end
         foreach (batch[i]) begin
            batch[i].sounding_count = sounding;
            batch[i].generation = gen_count;
            batch[i].last = (i == batch.size() - 1);
            expected_words.insert(expected_words.size(), batch[i]);
         end
      endfunction

      function void compare_field(string name, logic [31:0] want, logic [31:0] got);
         if (want !== got) begin
            $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
            errors++;
         end
      endfunction

      function void check_word(mst_pkg::mst_rsp_type got);
         mst_pkg::mst_rsp_type want;
         if (expected_words.size() == 0) begin
            $error("response word with nothing expected: kind %0d", got.kind);
            errors++;
            return;
         end
         want = expected_words.pop_front();
         compare_field("kind", 32'(want.kind), 32'(got.kind));
         compare_field("event_note", 32'(want.event_note), 32'(got.event_note));
         compare_field("release_mask", 32'(want.release_mask), 32'(got.release_mask));
         compare_field("is_sounding", 32'(want.is_sounding), 32'(got.is_sounding));
         compare_field("is_key_down", 32'(want.is_key_down), 32'(got.is_key_down));
         compare_field("sounding_count", 32'(want.sounding_count),
                       32'(got.sounding_count));
         compare_field("generation", want.generation, got.generation);
         compare_field("last", 32'(want.last), 32'(got.last));
      endfunction
   endclass

   logic                             clock;
   logic                             reset = 1'b1;
   // request side, all driven to known values from time zero
   logic                             req_valid = 1'b0;
   logic                             req_stall;
   logic [2:0]                       req_cmd = mst_pkg::CMD_QUERY;
   logic [mst_pkg::NOTE_FIELD_W-1:0] req_note = '0;
   logic [6:0]                       req_velocity = '0;
   logic                             req_pedal_down = 1'b0;
   // response side
   logic                             rsp_valid;
   logic                             rsp_stall = 1'b0;
   logic [1:0]                       rsp_kind;
   logic [mst_pkg::NOTE_FIELD_W-1:0] rsp_event_note;
   logic [mst_pkg::GROUP_SIZE-1:0]   rsp_release_mask;
   logic                             rsp_is_sounding;
   logic                             rsp_is_key_down;
   logic [7:0]                       rsp_sounding_count;
   logic [31:0]                      rsp_generation;
   logic                             rsp_last;
   // forwarding register
   logic                             csr_wr_en = 1'b0;
   logic                             csr_wr_data = 1'b0;

   sustain_scoreboard    sb;
   mst_pkg::mst_rsp_type seen_word;
   int                   cycle_count = 0;
   int                   send_idle_pct = 0;
   int                   stall_pct = 0;
   // long receiver hold-off, requested by the stimulus and counted below
   logic                 hold_req = 1'b0;
   logic                 hold_taken = 1'b0;
   int                   hold_left = 0;

   midi_sustain_note_tracker_top dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_cmd            (req_cmd),
      .req_note           (req_note),
      .req_velocity       (req_velocity),
      .req_pedal_down     (req_pedal_down),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_kind           (rsp_kind),
      .rsp_event_note     (rsp_event_note),
      .rsp_release_mask   (rsp_release_mask),
      .rsp_is_sounding    (rsp_is_sounding),
      .rsp_is_key_down    (rsp_is_key_down),
      .rsp_sounding_count (rsp_sounding_count),
      .rsp_generation     (rsp_generation),
      .rsp_last           (rsp_last),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data)
   );

   // 8 ns clock
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // response monitor, receiver stall and run limit; values read here are the
   // ones from before the edge, since everything else changes by nonblocking update
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         seen_word.kind = rsp_kind;
         seen_word.event_note = rsp_event_note;
         seen_word.release_mask = rsp_release_mask;
         seen_word.is_sounding = rsp_is_sounding;
         seen_word.is_key_down = rsp_is_key_down;
         seen_word.sounding_count = rsp_sounding_count;
         seen_word.generation = rsp_generation;
         seen_word.last = rsp_last;
         sb.check_word(seen_word);
      end
      // one long hold-off, otherwise random stall at the phase's rate
      if (hold_req && !hold_taken) begin
         hold_taken <= 1'b1;
         hold_left <= HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   // offer one request word, with a random gap in front, and wait until it is taken
   task automatic send_word(input logic [2:0] cmd, input logic [6:0] note,
                            input logic [6:0] vel, input logic pd);
      int gap;
      gap = 0;
      while (gap < 40 && $urandom_range(99) < send_idle_pct) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      // valid stays high straight into the next word when there is no gap
      req_valid <= 1'b1;
      req_cmd <= cmd;
      req_note <= note;
      req_velocity <= vel;
      req_pedal_down <= pd;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_request(cmd, note, vel, pd);
   endtask

   // every request yields at least one word, so an empty store means idle
   task automatic drain_block();
      while (sb.expected_words.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_forward(input logic value);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      sb.forward_on = value;
   endtask

   // field extremes, every command, velocity-zero off, sustain, re-press,
   // unchanged pedal, bulk release over several groups and empty all-off
   task automatic run_directed();
      send_word(mst_pkg::CMD_NOTE_ON, 7'd0, 7'd127, 1'b0);
      send_word(mst_pkg::CMD_NOTE_ON, 7'd127, 7'd1, 1'b1);
      send_word(mst_pkg::CMD_QUERY, 7'd127, 7'd0, 1'b0);
      send_word(mst_pkg::CMD_QUERY, 7'd5, 7'd127, 1'b1);
      send_word(mst_pkg::CMD_NOTE_ON, 7'd127, 7'd0, 1'b0);
      send_word(mst_pkg::CMD_NOTE_OFF, 7'd0, 7'd85, 1'b1);
      send_word(mst_pkg::CMD_PEDAL, 7'd42, 7'd0, 1'b1);
      send_word(mst_pkg::CMD_PEDAL, 7'd0, 7'd0, 1'b1);
      send_word(mst_pkg::CMD_NOTE_ON, 7'd16, 7'd64, 1'b0);
      send_word(mst_pkg::CMD_NOTE_ON, 7'd33, 7'd100, 1'b0);
      send_word(mst_pkg::CMD_NOTE_ON, 7'd100, 7'd7, 1'b0);
      send_word(mst_pkg::CMD_NOTE_OFF, 7'd16, 7'd0, 1'b0);
      send_word(mst_pkg::CMD_NOTE_ON, 7'd33, 7'd0, 1'b0);
      send_word(mst_pkg::CMD_QUERY, 7'd16, 7'd0, 1'b0);
      send_word(mst_pkg::CMD_NOTE_ON, 7'd16, 7'd90, 1'b0);
      send_word(mst_pkg::CMD_NOTE_OFF, 7'd100, 7'd0, 1'b0);
      send_word(mst_pkg::CMD_PEDAL, 7'd0, 7'd0, 1'b0);
      send_word(mst_pkg::CMD_PEDAL, 7'd127, 7'd127, 1'b0);
      // the three codes past query are unused
      send_word(mst_pkg::CMD_QUERY + 3'd1, 7'd127, 7'd127, 1'b1);
      send_word(mst_pkg::CMD_QUERY + 3'd2, 7'd16, 7'd127, 1'b1);
      send_word(mst_pkg::CMD_QUERY + 3'd3, 7'd0, 7'd0, 1'b0);
      send_word(mst_pkg::CMD_PEDAL, 7'd0, 7'd0, 1'b1);
      send_word(mst_pkg::CMD_NOTE_OFF, 7'd16, 7'd0, 1'b0);
      send_word(mst_pkg::CMD_ALL_OFF, 7'd0, 7'd0, 1'b0);
      send_word(mst_pkg::CMD_ALL_OFF, 7'd127, 7'd127, 1'b1);
   endtask

   // mostly note traffic on a small note pool so keys get pressed, released and
   // sustained again; pedal flips and all-off make the bulk releases
   task automatic random_word();
      logic [2:0] cmd;
      logic [6:0] note;
      logic [6:0] vel;
      logic       pd;
      int         pick;
      pick = $urandom_range(99);
      if (pick < 34) cmd = mst_pkg::CMD_NOTE_ON;
      else if (pick < 58) cmd = mst_pkg::CMD_NOTE_OFF;
      else if (pick < 70) cmd = mst_pkg::CMD_PEDAL;
      else if (pick < 75) cmd = mst_pkg::CMD_ALL_OFF;
      else if (pick < 92) cmd = mst_pkg::CMD_QUERY;
      else cmd = mst_pkg::CMD_QUERY + 3'($urandom_range(3, 1));
      if ($urandom_range(99) < 70) note = 7'($urandom_range(15) * 8 + $urandom_range(2));
      else note = 7'($urandom_range(127));
      if ($urandom_range(9) == 0) vel = 7'd0;
      else vel = 7'($urandom_range(127, 1));
      pd = 1'($urandom_range(1));
      send_word(cmd, note, vel, pd);
   endtask

   initial begin
      // phase traffic: none, sender idle, receiver stall, both lightly
      int send_tab [4];
      int stall_tab [4];
      send_tab = '{0, 81, 0, 15};
      stall_tab = '{0, 0, 81, 15};
      sb = new;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      for (int phase = 0; phase < 4; phase++) begin
         drain_block();
         send_idle_pct = send_tab[phase];
         stall_pct = stall_tab[phase];
         // forwarding alternates on, off, on, off
         write_forward(phase % 2 == 0);
         if (phase == 0) begin
            run_directed();
            // receiver holds off while the sender keeps offering words
            hold_req <= 1'b1;
         end
         repeat (ITEMS_PHASE) random_word();
         req_valid <= 1'b0;
      end
      drain_block();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (sb.expected_words.size() != 0) begin
         $error("%0d response words never arrived", sb.expected_words.size());
         sb.errors++;
      end
      if (sb.errors == 0) $display("Simulation PASSED");
      else $display("Simulation FAILED");
      $finish;
   end

endmodule

>>> filelist.f
hdl/mst_pkg.sv
hdl/mst_front.sv
hdl/mst_fifo.sv
hdl/mst_back.sv
hdl/midi_sustain_note_tracker_top.sv
sim/midi_sustain_note_tracker_top_tb.sv
